>>> rtl/tchlp_pkg.sv
// Package for the tagged comment hex line parser.
// Holds the parse state and result types, command codes, tag text and hex helpers.
// Has no dependencies; every RTL file of the block imports it.
package tchlp_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_HEADER,
		MODE_FRAME,
		MODE_CONT,
		MODE_DONE
	} mode_t;

	localparam logic [1:0] CMD_CHAR = 2'd0;
	localparam logic [1:0] CMD_EOL  = 2'd1;
	localparam logic [1:0] CMD_SRST = 2'd2;

	localparam logic [2:0] TAG_LEN    = 3'd5;
	localparam logic [2:0] TAG_FAILED = 3'd6;
	localparam logic [7:0] FIELD_NONE = 8'd255;

	typedef struct packed {
		mode_t       mode;
		logic [2:0]  tag_pos;
		logic [7:0]  field_idx;
		logic [3:0]  high_nib;
		logic        nib_pend;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] frames;
		logic        kf;
		logic        buf_ne;
	} parse_state_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  data_byte;
		logic        frame_start;
		logic        line_end;
		logic        line_had_data;
		logic [15:0] header_width;
		logic [15:0] header_height;
		logic [15:0] header_frames;
		logic        keyframe;
		logic        stream_ended;
	} result_t;

	function automatic logic [7:0] tag_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h4D;
			3'd1: c = 8'h53;
			3'd2: c = 8'h49;
			3'd3: c = 8'h4D;
			3'd4: c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else begin
			v = 8'h00;
		end
		return v[3:0];
	endfunction

endpackage

>>> rtl/tchlp_step.sv
// Next-state and result logic for one parser word.
// Depends on tchlp_pkg for the state and result types and the hex helpers.
module tchlp_step
	import tchlp_pkg::*;
(
	input  parse_state_t cur,
	input  logic [1:0]   cmd,
	input  logic [7:0]   ch,
	output parse_state_t nxt,
	output result_t      res
);

	logic       bvalid;
	logic [7:0] bval;
	logic       fstart;
	logic       lend;
	logic       had;
	logic       is_blank;

	assign is_blank = (ch == 8'h3B) || (ch == 8'h20) || (ch == 8'h09);

	always_comb begin
		nxt    = cur;
		bvalid = 1'b0;
		bval   = 8'h00;
		fstart = 1'b0;
		lend   = 1'b0;
		had    = 1'b0;
		case (cmd)
			CMD_CHAR: begin
				case (cur.mode)
					MODE_IDLE: begin
						if (cur.tag_pos == 3'd0 && is_blank) begin
							nxt = cur;
						end else if (cur.tag_pos < TAG_LEN) begin
							if (ch == tag_char(cur.tag_pos)) begin
								nxt.tag_pos = cur.tag_pos + 3'd1;
								if (cur.tag_pos + 3'd1 == TAG_LEN) begin
									nxt.field_idx = 8'd0;
								end
							end else begin
								nxt.tag_pos = TAG_FAILED;
							end
						end else if (cur.tag_pos == TAG_LEN) begin
							case (ch)
								8'h48, 8'h68: begin
									nxt.mode      = MODE_HEADER;
									nxt.field_idx = FIELD_NONE;
									nxt.width     = 16'd0;
									nxt.height    = 16'd0;
									nxt.frames    = 16'd0;
								end
								8'h46, 8'h66, 8'h4B, 8'h6B: begin
									nxt.mode      = MODE_FRAME;
									nxt.field_idx = FIELD_NONE;
									nxt.kf        = (ch == 8'h4B) || (ch == 8'h6B);
									nxt.buf_ne    = 1'b0;
									nxt.nib_pend  = 1'b0;
									fstart        = 1'b1;
								end
								8'h43, 8'h63: begin
									nxt.mode      = MODE_CONT;
									nxt.field_idx = 8'd0;
									nxt.nib_pend  = 1'b0;
								end
								8'h45, 8'h65: begin
									nxt.mode = MODE_DONE;
								end
								default: begin
									nxt.mode    = MODE_IDLE;
									nxt.tag_pos = 3'd0;
								end
							endcase
						end
					end
					MODE_HEADER: begin
						if (ch == 8'h3A) begin
							nxt.field_idx = cur.field_idx + 8'd1;
						end else if (is_hex(ch)) begin
							if (cur.field_idx == 8'd0) begin
								nxt.width = {cur.width[11:0], hex_value(ch)};
							end else if (cur.field_idx == 8'd1) begin
								nxt.height = {cur.height[11:0], hex_value(ch)};
							end else if (cur.field_idx == 8'd2) begin
								nxt.frames = {cur.frames[11:0], hex_value(ch)};
							end
						end
					end
					MODE_FRAME, MODE_CONT: begin
						if (ch == 8'h3A) begin
							nxt.field_idx = cur.field_idx + 8'd1;
							nxt.nib_pend  = 1'b0;
						end else if ((cur.mode == MODE_CONT || cur.field_idx != 8'd0) &&
							is_hex(ch)) begin
							if (!cur.nib_pend) begin
								nxt.high_nib = hex_value(ch);
								nxt.nib_pend = 1'b1;
							end else begin
								bvalid       = 1'b1;
								bval         = {cur.high_nib, hex_value(ch)};
								nxt.nib_pend = 1'b0;
								nxt.buf_ne   = 1'b1;
							end
						end
					end
					default: begin
						nxt = cur;
					end
				endcase
			end
			CMD_EOL: begin
				lend = 1'b1;
				if (cur.mode == MODE_HEADER) begin
					had = 1'b1;
				end else if (cur.mode == MODE_FRAME || cur.mode == MODE_CONT) begin
					had = cur.buf_ne;
				end
				nxt.mode      = MODE_IDLE;
				nxt.tag_pos   = 3'd0;
				nxt.field_idx = 8'd0;
				nxt.nib_pend  = 1'b0;
			end
			CMD_SRST: begin
				nxt = '{mode: MODE_IDLE, default: '0};
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_comb begin
		res.byte_valid    = bvalid;
		res.data_byte     = bval;
		res.frame_start   = fstart;
		res.line_end      = lend;
		res.line_had_data = had;
		res.header_width  = nxt.width;
		res.header_height = nxt.height;
		res.header_frames = nxt.frames;
		res.keyframe      = nxt.kf;
		res.stream_ended  = (nxt.mode == MODE_DONE);
	end

endmodule

>>> rtl/tagged_comment_hex_line_parser.sv
// Tagged comment hex line parser, top level: input register, parse state and result register.
// Depends on tchlp_pkg and tchlp_step.
// An accepted word is held in the input register, then goes through the parse step into the result register.
// Throughput: one word per cycle while the master side does not stall it through m_tready.
// Reset: arst_n clears the parse state and both stage valid flags at once.
module tagged_comment_hex_line_parser
	import tchlp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] ch
	input  logic [1:0]  s_tuser,  // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [7:0] data_byte, [8] frame_start, [9] line_had_data,
	                              // [25:10] header_width, [41:26] header_height,
	                              // [57:42] header_frames, [58] keyframe, [59] stream_ended
	output logic        m_tuser,  // [0] byte_valid
	output logic        m_tlast   // line_end
);

	logic         valid_s1;
	logic [1:0]   cmd_s1;
	logic [7:0]   ch_s1;
	logic         out_valid_q;
	result_t      out_q;
	parse_state_t state_q;
	parse_state_t state_d;
	result_t      res_d;
	logic         advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	tchlp_step u_step (
		.cur (state_q),
		.cmd (cmd_s1),
		.ch  (ch_s1),
		.nxt (state_d),
		.res (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tuser;
			ch_s1  <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{mode: MODE_IDLE, default: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_d;
			end
			if (!out_valid_q || m_tready) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.byte_valid;
	assign m_tlast  = out_q.line_end;
	assign m_tdata  = {4'd0, out_q.stream_ended, out_q.keyframe, out_q.header_frames,
		out_q.header_height, out_q.header_width, out_q.line_had_data,
		out_q.frame_start, out_q.data_byte};

	a_tag_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.tag_pos != 3'd7)
		else $error("Tag position holds an unused code.");

	a_byte_marks_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.byte_valid |-> state_q.buf_ne)
		else $error("A byte was emitted without the buffer being marked non-empty.");

	a_frame_start_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_start |-> state_q.mode == MODE_FRAME)
		else $error("A frame start was reported outside frame mode.");

	a_nibble_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.nib_pend |-> (state_q.mode == MODE_FRAME || state_q.mode == MODE_CONT))
		else $error("A nibble is pending outside a data line.");

	a_ended_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.stream_ended == (state_q.mode == MODE_DONE))
		else $error("The end flag disagrees with the parse mode.");

endmodule
